// ----- hw/rtl/multi_input_debouncer_macros.svh -----
// ----------------------------------------------------------------------------
// Multi-input debouncer assertion macros
// Shared property wrappers for the debouncer checkers.
// ----------------------------------------------------------------------------
`ifndef MULTI_INPUT_DEBOUNCER_MACROS_SVH
`define MULTI_INPUT_DEBOUNCER_MACROS_SVH

// Checked only while out of reset.
`define DBNC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define DBNC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/dbnc_pkg.sv -----
// ----------------------------------------------------------------------------
// Debouncer package
// Widths, reset values, register indexes and lane interface types.
// ----------------------------------------------------------------------------
package dbnc_pkg;

  localparam int PinW           = 8;
  localparam int CntW           = 8;
  localparam int CfgIdxW        = 2;
  localparam int CfgDataW       = 8;
  localparam int NumInputsDef   = 8;

  localparam logic [CntW-1:0] IdleCount     = 8'hFF;
  localparam logic [CntW-1:0] DebounceReset = 8'd20;
  localparam logic [PinW-1:0] ReportEnReset = 8'h00;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE_TIME = 2'd0,
    REG_REPORT_ENABLE = 2'd1
  } cfg_reg_e;

  // Shared per-scan control fanned out to every lane
  typedef struct packed {
    logic accept;
    logic started;
    logic tick;
  } lane_ctrl_t;

  // Next-state view of one lane, merged into the result word
  typedef struct packed {
    logic level;
    logic pending;
    logic settling;
  } lane_out_t;

endpackage

// ----- hw/rtl/multi_input_debouncer.sv -----
// ----------------------------------------------------------------------------
// Multi-input debouncer
// Counter-based debounce of a pin scan, one lane per pin, merged result word.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake                    | payload
//  s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata: pins, report_clear; tuser: tick
//  m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata: levels, pending, settling
//  cfg       | in  | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
//
//  One scan per cycle; every lane updates in the accept cycle and the
//  result word appears in the output register on the next cycle.
//  Throughput is set by the output register: a new scan is taken whenever
//  it is empty or being drained in the same cycle.
//  Reset: all counters idle, levels and report flags zero, output empty.
//  Config writes are always ready and take effect on the next scan.
// ----------------------------------------------------------------------------
module multi_input_debouncer #(
  parameter int NumInputs = dbnc_pkg::NumInputsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: [7:0] pins, [15:8] report_clear
  input  logic [2*dbnc_pkg::PinW-1:0]       s_axis_tdata,
  // tuser: [0] tick
  input  logic                              s_axis_tuser,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: [7:0] debounced_levels, [15:8] report_pending, [23:16] settling
  output logic [3*dbnc_pkg::PinW-1:0]       m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dbnc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [dbnc_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int PinW     = dbnc_pkg::PinW;
  localparam int NumLanes = (NumInputs < PinW) ? NumInputs : PinW;

  logic [dbnc_pkg::CntW-1:0] debounce_time_q;
  logic [PinW-1:0]           report_en_q;
  logic                      started_q;
  logic                      out_valid_q;
  logic [PinW-1:0]           levels_q, pending_q, settling_q;
  logic [PinW-1:0]           levels_d, pending_d, settling_d;
  logic [PinW-1:0]           pins, clr;
  logic                      in_accept;
  dbnc_pkg::lane_ctrl_t      ctrl;

  assign pins          = s_axis_tdata[PinW-1:0];
  assign clr           = s_axis_tdata[2*PinW-1:PinW];
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign ctrl.accept  = in_accept;
  assign ctrl.started = started_q;
  assign ctrl.tick    = s_axis_tuser;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_time_q <= dbnc_pkg::DebounceReset;
      report_en_q     <= dbnc_pkg::ReportEnReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dbnc_pkg::REG_DEBOUNCE_TIME: debounce_time_q <= cfg_data_i;
        dbnc_pkg::REG_REPORT_ENABLE: report_en_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < PinW; i++) begin : g_lane
    if (i < NumLanes) begin : g_on
      dbnc_pkg::lane_out_t lane_out;
      dbnc_lane u_lane (
        .clk_i           (clk_i),
        .rst_ni          (rst_ni),
        .ctrl_i          (ctrl),
        .pin_i           (pins[i]),
        .clr_i           (clr[i]),
        .report_en_i     (report_en_q[i]),
        .debounce_time_i (debounce_time_q),
        .lane_o          (lane_out)
      );
      assign levels_d[i]   = lane_out.level;
      assign pending_d[i]  = lane_out.pending;
      assign settling_d[i] = lane_out.settling;
    end else begin : g_off
      assign levels_d[i]   = 1'b0;
      assign pending_d[i]  = 1'b0;
      assign settling_d[i] = 1'b0;
    end
  end

  // merge stage: lane bits into the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        started_q <= 1'b1;
      end
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      levels_q   <= levels_d;
      pending_q  <= pending_d;
      settling_q <= settling_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {settling_q, pending_q, levels_q};

endmodule

// ----- hw/rtl/dbnc_lane.sv -----
// ----------------------------------------------------------------------------
// Debouncer lane
// Wait counter, debounced level and sticky report flag for one pin.
// ----------------------------------------------------------------------------
module dbnc_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dbnc_pkg::lane_ctrl_t          ctrl_i,
  input  logic                          pin_i,
  input  logic                          clr_i,
  input  logic                          report_en_i,
  input  logic [dbnc_pkg::CntW-1:0]     debounce_time_i,
  output dbnc_pkg::lane_out_t           lane_o
);

  logic [dbnc_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                      level_q, level_d;
  logic                      pend_q, pend_d;
  logic                      level_eff;
  logic                      differs;

  // first scan after reset takes the level straight from the pin
  assign level_eff = ctrl_i.started ? level_q : pin_i;
  assign differs   = pin_i ^ level_eff;

  always_comb begin
    cnt_d   = cnt_q;
    level_d = level_eff;
    pend_d  = pend_q & ~clr_i;
    if (cnt_q == dbnc_pkg::IdleCount) begin
      if (differs) begin
        cnt_d = debounce_time_i;
      end
    end else if (cnt_q == '0) begin
      if (differs) begin
        level_d = ~level_eff;
        pend_d  = report_en_i;
      end
      cnt_d = dbnc_pkg::IdleCount;
    end else if (ctrl_i.tick) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= dbnc_pkg::IdleCount;
      level_q <= 1'b0;
      pend_q  <= 1'b0;
    end else if (ctrl_i.accept) begin
      cnt_q   <= cnt_d;
      level_q <= level_d;
      pend_q  <= pend_d;
    end
  end

  assign lane_o.level    = level_d;
  assign lane_o.pending  = pend_d;
  assign lane_o.settling = (cnt_d != dbnc_pkg::IdleCount);

endmodule

// ----- hw/rtl/dbnc_checker.sv -----
// ----------------------------------------------------------------------------
// Debouncer port checker
// Handshake and pacing checks on the top-level ports.
// ----------------------------------------------------------------------------
`include "multi_input_debouncer_macros.svh"

module dbnc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [3*dbnc_pkg::PinW-1:0]       m_axis_tdata,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready
);

  logic in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // stalled result word holds
  `DBNC_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result word dropped or changed under stall")
  // every accepted scan gives a word next cycle
  `DBNC_ASSERT(a_scan_result, clk_i, rst_ni, in_acc |=> m_axis_tvalid, "accepted scan produced no word")
  // a drained word with no new scan leaves the output empty
  `DBNC_ASSERT(a_no_extra, clk_i, rst_ni, out_acc && !in_acc |=> !m_axis_tvalid, "word repeated or invented")
  // an empty output register never blocks input
  `DBNC_ASSERT(a_ready_empty, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready, "input stalled while output empty")
  `DBNC_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> !m_axis_tvalid, "word shown during reset")

endmodule

bind multi_input_debouncer dbnc_checker u_dbnc_checker (.*);

// ----- tb/sv/multi_input_debouncer_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multi-input debouncer testbench
// Streams pin scans through the debouncer with random gaps on both sides and
// checks every result word against a cycle-free model of the per-pin wait
// counters. A short directed table covers first scan, zero wait, a wait
// equal to idle, glitches that vanish before the wait ends, report enable
// and clear, and writes to unused register indexes. Random phases follow.
// ----------------------------------------------------------------------------
module multi_input_debouncer_test;

  localparam int PinW     = dbnc_pkg::PinW;
  localparam int CntW     = dbnc_pkg::CntW;
  localparam int CfgIdxW  = dbnc_pkg::CfgIdxW;
  localparam int CfgDataW = dbnc_pkg::CfgDataW;
  localparam int NumPins  = dbnc_pkg::NumInputsDef;
  localparam logic [CfgIdxW-1:0] RegUnusedA = 2'd2;
  localparam logic [CfgIdxW-1:0] RegUnusedB = 2'd3;

  typedef struct packed {
    logic [PinW-1:0] levels;
    logic [PinW-1:0] pending;
    logic [PinW-1:0] settling;
  } scan_result_t;

  typedef enum logic {ROW_SCAN, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [PinW-1:0]    pins;
    logic               tick;
    logic [PinW-1:0]    clr;
    logic [CfgIdxW-1:0] idx;
    logic [CfgDataW-1:0] data;
    bit                 known;
    scan_result_t       res;
  } dir_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b1;
  logic [2*PinW-1:0]      s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [3*PinW-1:0]      m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxW-1:0]     cfg_index_i = '0;
  logic [CfgDataW-1:0]    cfg_data_i = '0;

  multi_input_debouncer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // model state
  logic [PinW-1:0] lvl_q = '0;
  logic [PinW-1:0] pend_q = '0;
  logic [CntW-1:0] wait_q [NumPins];
  bit              started_q = 1'b0;
  logic [CntW-1:0] dbt_q = dbnc_pkg::DebounceReset;
  logic [PinW-1:0] ren_q = dbnc_pkg::ReportEnReset;

  scan_result_t debounce_words_q [$];
  dir_row_t     dir_rows [$];
  logic [PinW-1:0] pin_target = '0;
  bit calm = 1'b0;

  int err_count = 0;
  int scans_sent = 0;
  int words_checked = 0;
  int flips_seen = 0;
  int reg_writes = 0;

  initial begin
    foreach (wait_q[i]) wait_q[i] = dbnc_pkg::IdleCount;
  end

  task automatic debounce_scan(input logic [PinW-1:0] p, input logic t,
                               input logic [PinW-1:0] c, output scan_result_t r);
    logic [PinW-1:0] settle;
    bit differs;
    settle = '0;
    pend_q &= ~c;
    if (!started_q) begin
      lvl_q = p;
      started_q = 1'b1;
    end
    for (int i = 0; i < NumPins; i++) begin
      differs = p[i] ^ lvl_q[i];
      if (wait_q[i] == dbnc_pkg::IdleCount) begin
        if (differs) wait_q[i] = dbt_q;
      end else if (wait_q[i] == '0) begin
        // wait over: flip only if the pin still disagrees
        if (differs) begin
          lvl_q[i] = ~lvl_q[i];
          pend_q[i] = ren_q[i];
          flips_seen++;
        end
        wait_q[i] = dbnc_pkg::IdleCount;
      end else if (t) begin
        wait_q[i] = wait_q[i] - 1'b1;
      end
      settle[i] = (wait_q[i] != dbnc_pkg::IdleCount);
    end
    r = '{lvl_q, pend_q, settle};
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 30);
  end

  always @(posedge clk_i) begin
    scan_result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (debounce_words_q.size() == 0) begin
        $error("result word %06h with no scan outstanding", m_axis_tdata);
        err_count++;
      end else begin
        e = debounce_words_q.pop_front();
        words_checked++;
        if (m_axis_tdata[7:0] !== e.levels) begin
          $error("debounced_levels: expected %02h, got %02h", e.levels, m_axis_tdata[7:0]);
          err_count++;
        end
        if (m_axis_tdata[15:8] !== e.pending) begin
          $error("report_pending: expected %02h, got %02h", e.pending, m_axis_tdata[15:8]);
          err_count++;
        end
        if (m_axis_tdata[23:16] !== e.settling) begin
          $error("settling: expected %02h, got %02h", e.settling, m_axis_tdata[23:16]);
          err_count++;
        end
      end
    end
  end

  task automatic send_scan(input logic [PinW-1:0] p, input logic t,
                           input logic [PinW-1:0] c, input bit known,
                           input scan_result_t typed);
    scan_result_t r;
    while (!calm && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c, p};
    s_axis_tuser  <= t;
    do @(posedge clk_i); while (!s_axis_tready);
    debounce_scan(p, t, c, r);
    debounce_words_q.push_back(known ? typed : r);
    scans_sent++;
  endtask

  // stop feeding and wait until every word has come back
  task automatic settle_out();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (debounce_words_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == dbnc_pkg::REG_DEBOUNCE_TIME) dbt_q = d;
    else if (idx == dbnc_pkg::REG_REPORT_ENABLE) ren_q = d;
    reg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic dir_row_t scan_row(logic [PinW-1:0] p, logic t, logic [PinW-1:0] c);
    return '{ROW_SCAN, p, t, c, dbnc_pkg::REG_DEBOUNCE_TIME, 8'h00, 1'b0, '0};
  endfunction

  function automatic dir_row_t known_row(logic [PinW-1:0] p, logic t, logic [PinW-1:0] c,
                                         logic [PinW-1:0] lv, logic [PinW-1:0] pd,
                                         logic [PinW-1:0] st);
    return '{ROW_SCAN, p, t, c, dbnc_pkg::REG_DEBOUNCE_TIME, 8'h00, 1'b1, '{lv, pd, st}};
  endfunction

  function automatic dir_row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    return '{ROW_CFG, 8'h00, 1'b0, 8'h00, idx, d, 1'b0, '0};
  endfunction

  // well-formed runs: a target pattern held for a while, plus glitches and noise
  task automatic run_phase(input logic [CntW-1:0] dbt, input logic [PinW-1:0] ren,
                           input int n, input int tick_pct, input int hold);
    logic [PinW-1:0] p;
    logic [PinW-1:0] c;
    logic t;
    settle_out();
    write_reg(dbnc_pkg::REG_DEBOUNCE_TIME, dbt);
    write_reg(dbnc_pkg::REG_REPORT_ENABLE, ren);
    pin_target = 8'($urandom);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(hold - 1) == 0) pin_target = 8'($urandom);
      p = pin_target;
      if ($urandom_range(99) < 12) p ^= 8'(1) << $urandom_range(PinW - 1);
      if ($urandom_range(99) < 5) p = 8'($urandom);
      t = ($urandom_range(99) < tick_pct);
      c = ($urandom_range(99) < 25) ? 8'($urandom) : 8'h00;
      send_scan(p, t, c, 1'b0, '0);
    end
  endtask

  initial begin
    // first scan loads levels straight from the pins
    dir_rows.push_back(known_row(8'hA5, 1'b0, 8'h00, 8'hA5, 8'h00, 8'h00));
    // zero wait: change seen, decided on the next scan
    dir_rows.push_back(cfg_row(dbnc_pkg::REG_DEBOUNCE_TIME, 8'h00));
    dir_rows.push_back(cfg_row(dbnc_pkg::REG_REPORT_ENABLE, 8'hFF));
    dir_rows.push_back(scan_row(8'h5A, 1'b1, 8'h00));
    dir_rows.push_back(known_row(8'h5A, 1'b0, 8'h00, 8'h5A, 8'hFF, 8'h00));
    dir_rows.push_back(scan_row(8'h5A, 1'b0, 8'h0F));
    // two-tick wait; a glitch that is gone when the wait ends
    dir_rows.push_back(cfg_row(dbnc_pkg::REG_DEBOUNCE_TIME, 8'h02));
    dir_rows.push_back(cfg_row(dbnc_pkg::REG_REPORT_ENABLE, 8'h0F));
    dir_rows.push_back(scan_row(8'hA5, 1'b1, 8'h00));
    dir_rows.push_back(scan_row(8'hA5, 1'b1, 8'h00));
    dir_rows.push_back(scan_row(8'hA5, 1'b0, 8'h00));
    dir_rows.push_back(scan_row(8'hA5, 1'b1, 8'h00));
    dir_rows.push_back(scan_row(8'h5A, 1'b1, 8'h00));
    // real change; disabled pins lose their pending flag on the flip
    dir_rows.push_back(scan_row(8'hA5, 1'b1, 8'h00));
    dir_rows.push_back(scan_row(8'hA5, 1'b1, 8'h00));
    dir_rows.push_back(scan_row(8'hA5, 1'b1, 8'h00));
    dir_rows.push_back(scan_row(8'hA5, 1'b0, 8'h00));
    // wait value equal to idle never settles
    dir_rows.push_back(cfg_row(dbnc_pkg::REG_DEBOUNCE_TIME, 8'hFF));
    dir_rows.push_back(known_row(8'h00, 1'b1, 8'h00, 8'hA5, 8'h0F, 8'h00));
    dir_rows.push_back(known_row(8'hFF, 1'b1, 8'hFF, 8'hA5, 8'h00, 8'h00));
    // unused register indexes must not disturb anything
    dir_rows.push_back(cfg_row(dbnc_pkg::REG_DEBOUNCE_TIME, 8'h01));
    dir_rows.push_back(cfg_row(RegUnusedA, 8'h00));
    dir_rows.push_back(cfg_row(RegUnusedB, 8'hFF));
    dir_rows.push_back(scan_row(8'h5A, 1'b1, 8'h00));
    dir_rows.push_back(scan_row(8'h5A, 1'b1, 8'h00));
    dir_rows.push_back(scan_row(8'h5A, 1'b0, 8'h00));
    dir_rows.push_back(scan_row(8'h00, 1'b0, 8'hFF));
    dir_rows.push_back(scan_row(8'hFF, 1'b1, 8'h00));

    // assert reset with a real falling edge so the flops clear before the first clock
    #1 rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        settle_out();
        write_reg(dir_rows[k].idx, dir_rows[k].data);
      end else begin
        send_scan(dir_rows[k].pins, dir_rows[k].tick, dir_rows[k].clr,
                  dir_rows[k].known, dir_rows[k].res);
      end
    end

    run_phase(8'($urandom_range(3)), 8'($urandom), 120, 50, 8);
    // longest legal wait, nearly every scan ticking
    run_phase(8'd254, 8'hFF, 300, 95, 1000);
    calm <= 1'b1;
    run_phase(8'h00, 8'h00, 100, 50, 4);
    calm <= 1'b0;
    run_phase(8'($urandom_range(10, 1)), 8'($urandom), 230, 70, 20);

    settle_out();
    repeat (8) @(posedge clk_i);
    $display("%0d scans sent, %0d words checked, %0d debounced flips, %0d register writes",
             scans_sent, words_checked, flips_seen, reg_writes);
    $display("wait times 0 to 10, 254 and 255; report masks from none to all pins");
    if (err_count == 0) begin
      $display("multi_input_debouncer_test: clean");
    end else begin
      $display("multi_input_debouncer_test: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("multi_input_debouncer_test: errors");
    $finish;
  end

endmodule
